@@ sv/ordered_list_engine_unit_macros.svh @@
// Assertion macros shared by the ordered list engine RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`define ORDERED_LIST_ENGINE_UNIT_MACROS_SVH

`ifndef SYNTH
// Clocked check, held off while reset is asserted.
`define OLU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check, active through reset.
`define OLU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define OLU_ASSERT(lbl, clk, rst_n, prop, msg)
`define OLU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ sv/olq_pkg.sv @@
// Package for the ordered list engine: sizes, codes, controller/datapath types.
// No dependencies.
package olq_pkg;

    localparam int CAPACITY  = 256;
    localparam int ITEM_BITS = 16;

    localparam int FUNC_W   = 3;
    localparam int ITEM_W   = 16;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int STORE_W = (ITEM_BITS < ITEM_W) ? ITEM_BITS : ITEM_W;
    localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;

    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = FUNC_W'(0);
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = FUNC_W'(2);
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = FUNC_W'(3);
    localparam logic [FUNC_W-1:0] FN_DELETE     = FUNC_W'(4);

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH_FRONT,
        S_FETCH_BACK,
        S_SHIFT,
        S_RESP
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_PUSH_BACK,
        OP_PUSH_FRONT,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_SHIFT_START,
        OP_SHIFT_STEP,
        OP_SHIFT_END,
        OP_FETCH_FRONT,
        OP_FETCH_BACK
    } t_dp_op;

    typedef struct packed {
        logic    load_req;
        t_dp_op  op;
        logic    set_status;
        t_status status;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              empty;
        logic              full;
        logic              pos_range;
        logic              pos_last;
        logic              count_one;
        logic              shift_last;
        logic              out_free;
    } t_dp_stat;

    // Ring slot of base + off, both below CAPACITY.
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                   input logic [SLOT_W-1:0] off);
        logic [SLOT_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (SLOT_W+1)'(CAPACITY)) begin
            sum = sum - (SLOT_W+1)'(CAPACITY);
        end
        return sum[SLOT_W-1:0];
    endfunction

    // Ring slot one before base.
    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] base);
        logic [SLOT_W-1:0] res;
        if (base == '0) begin
            res = SLOT_W'(CAPACITY - 1);
        end else begin
            res = base - SLOT_W'(1);
        end
        return res;
    endfunction

endpackage

@@ sv/olq_req_if.sv @@
// Request channel of the ordered list engine: valid/ready plus request fields.
// Depends on olq_pkg.
interface olq_req_if import olq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ITEM_W-1:0] item;
    logic [POS_W-1:0]  position;

    modport source (output valid, output func, output item, output position, input ready);
    modport sink   (input valid, input func, input item, input position, output ready);
endinterface

@@ sv/olq_rsp_if.sv @@
// Response channel of the ordered list engine: valid/ready plus result fields.
// Depends on olq_pkg.
interface olq_rsp_if import olq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ITEM_W-1:0]   front_item;
    logic [ITEM_W-1:0]   back_item;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output front_item, output back_item,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input front_item, input back_item,
                    input entry_count, output ready);
endinterface

@@ sv/olq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module olq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/olq_ctrl.sv @@
// Controller of the ordered list engine: sequences one request at a time.
// Depends on olq_pkg; drives datapath commands, reads datapath status.
module olq_ctrl import olq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
                case (i_stat.func)
                    FN_POP_FRONT: begin
                        if (!i_stat.empty && !i_stat.count_one) begin
                            n_state = S_FETCH_FRONT;
                        end
                    end
                    FN_POP_BACK: begin
                        if (!i_stat.empty && !i_stat.count_one) begin
                            n_state = S_FETCH_BACK;
                        end
                    end
                    FN_DELETE: begin
                        if (!i_stat.empty && !i_stat.pos_range) begin
                            if (i_stat.pos_last) begin
                                if (!i_stat.count_one) begin
                                    n_state = S_FETCH_BACK;
                                end
                            end else begin
                                n_state = S_SHIFT;
                            end
                        end
                    end
                    default: n_state = S_RESP;
                endcase
            end
            S_FETCH_FRONT: n_state = S_RESP;
            S_FETCH_BACK:  n_state = S_RESP;
            S_SHIFT: begin
                if (i_stat.shift_last) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd        = '0;
        o_cmd.op     = OP_NONE;
        o_cmd.status = ST_DONE;
        o_req_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready    = 1'b1;
                o_cmd.load_req = i_req_valid;
            end
            S_EXEC: begin
                o_cmd.set_status = 1'b1;
                case (i_stat.func)
                    FN_PUSH_BACK, FN_PUSH_FRONT: begin
                        if (i_stat.full) begin
                            o_cmd.status = ST_FULL;
                        end else if (i_stat.func == FN_PUSH_BACK) begin
                            o_cmd.op = OP_PUSH_BACK;
                        end else begin
                            o_cmd.op = OP_PUSH_FRONT;
                        end
                    end
                    FN_POP_FRONT: begin
                        if (i_stat.empty) begin
                            o_cmd.status = ST_EMPTY;
                        end else begin
                            o_cmd.op = OP_POP_FRONT;
                        end
                    end
                    FN_POP_BACK: begin
                        if (i_stat.empty) begin
                            o_cmd.status = ST_EMPTY;
                        end else begin
                            o_cmd.op = OP_POP_BACK;
                        end
                    end
                    FN_DELETE: begin
                        if (i_stat.empty) begin
                            o_cmd.status = ST_EMPTY;
                        end else if (i_stat.pos_range) begin
                            o_cmd.status = ST_RANGE;
                        end else if (i_stat.pos_last) begin
                            // Dropping the back entry is a pop back.
                            o_cmd.op = OP_POP_BACK;
                        end else begin
                            o_cmd.op = OP_SHIFT_START;
                        end
                    end
                    default: o_cmd.op = OP_NONE;
                endcase
            end
            S_FETCH_FRONT: o_cmd.op = OP_FETCH_FRONT;
            S_FETCH_BACK:  o_cmd.op = OP_FETCH_BACK;
            S_SHIFT: begin
                o_cmd.op = i_stat.shift_last ? OP_SHIFT_END : OP_SHIFT_STEP;
            end
            S_RESP: o_cmd.load_out = i_stat.out_free;
            default: o_cmd.op = OP_NONE;
        endcase
    end
endmodule

@@ sv/olq_dp.sv @@
// Datapath of the ordered list engine: ring pointers, entry RAM, front/back cache,
// output register. Depends on olq_pkg, olq_ram and the assertion macros.
`include "ordered_list_engine_unit_macros.svh"

module olq_dp import olq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [ITEM_W-1:0]   i_item,
    input  logic [POS_W-1:0]    i_pos,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [ITEM_W-1:0]   o_front_item,
    output logic [ITEM_W-1:0]   o_back_item,
    output logic [COUNT_W-1:0]  o_entry_count
);
    logic [FUNC_W-1:0]   r_func;
    logic [STORE_W-1:0]  r_item;
    logic [POS_W-1:0]    r_pos;
    logic [SLOT_W-1:0]   r_head;
    logic [CNT_W-1:0]    r_count;
    logic [SLOT_W-1:0]   r_idx;
    logic [STORE_W-1:0]  r_front;
    logic [STORE_W-1:0]  r_back;
    t_status             r_status;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [ITEM_W-1:0]   r_out_front;
    logic [ITEM_W-1:0]   r_out_back;
    logic [COUNT_W-1:0]  r_out_count;

    logic                we;
    logic [SLOT_W-1:0]   waddr;
    logic [STORE_W-1:0]  wdata;
    logic [SLOT_W-1:0]   raddr;
    logic [STORE_W-1:0]  rdata;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic [CMP_W-1:0]    idx_ext;

    assign pos_ext = CMP_W'(r_pos);
    assign cnt_ext = CMP_W'(r_count);
    assign idx_ext = CMP_W'(r_idx);

    always_comb begin
        o_stat.func       = r_func;
        o_stat.empty      = (r_count == '0);
        o_stat.full       = (r_count >= CNT_W'(CAPACITY));
        o_stat.pos_range  = (pos_ext >= cnt_ext);
        o_stat.pos_last   = (pos_ext + CMP_W'(1) == cnt_ext);
        o_stat.count_one  = (r_count == CNT_W'(1));
        o_stat.shift_last = (idx_ext + CMP_W'(2) == cnt_ext);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // RAM addressing per command
    always_comb begin
        we    = 1'b0;
        waddr = r_head;
        wdata = rdata;
        raddr = r_head;
        case (i_cmd.op)
            OP_PUSH_BACK: begin
                we    = 1'b1;
                waddr = slot_add(r_head, SLOT_W'(r_count));
                wdata = r_item;
            end
            OP_PUSH_FRONT: begin
                we    = 1'b1;
                waddr = slot_dec(r_head);
                wdata = r_item;
            end
            OP_POP_FRONT:   raddr = slot_add(r_head, SLOT_W'(1));
            OP_POP_BACK:    raddr = slot_add(r_head, SLOT_W'(r_count - CNT_W'(2)));
            OP_SHIFT_START: raddr = slot_add(r_head, SLOT_W'(r_pos) + SLOT_W'(1));
            OP_SHIFT_STEP: begin
                we    = 1'b1;
                waddr = slot_add(r_head, r_idx);
                raddr = slot_add(r_head, r_idx + SLOT_W'(2));
            end
            OP_SHIFT_END: begin
                we    = 1'b1;
                waddr = slot_add(r_head, r_idx);
            end
            default: we = 1'b0;
        endcase
    end

    olq_ram #(
        .WIDTH (STORE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_PUSH_BACK: r_count <= r_count + CNT_W'(1);
                OP_PUSH_FRONT: begin
                    r_head  <= slot_dec(r_head);
                    r_count <= r_count + CNT_W'(1);
                end
                OP_POP_FRONT: begin
                    r_head  <= slot_add(r_head, SLOT_W'(1));
                    r_count <= r_count - CNT_W'(1);
                end
                OP_POP_BACK:  r_count <= r_count - CNT_W'(1);
                OP_SHIFT_END: r_count <= r_count - CNT_W'(1);
                default:      r_count <= r_count;
            endcase
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_func <= i_func;
            r_item <= STORE_W'(i_item);
            r_pos  <= i_pos;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        case (i_cmd.op)
            OP_PUSH_BACK: begin
                r_back <= r_item;
                if (r_count == '0) begin
                    r_front <= r_item;
                end
            end
            OP_PUSH_FRONT: begin
                r_front <= r_item;
                if (r_count == '0) begin
                    r_back <= r_item;
                end
            end
            OP_SHIFT_START: r_idx <= SLOT_W'(r_pos);
            OP_SHIFT_STEP: begin
                if (r_idx == '0) begin
                    r_front <= rdata;
                end
                r_idx <= r_idx + SLOT_W'(1);
            end
            OP_SHIFT_END: begin
                if (r_idx == '0) begin
                    r_front <= rdata;
                end
            end
            OP_FETCH_FRONT: r_front <= rdata;
            OP_FETCH_BACK:  r_back  <= rdata;
            default:        r_idx   <= r_idx;
        endcase
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_front  <= (r_count == '0) ? '0 : ITEM_W'(r_front);
            r_out_back   <= (r_count == '0) ? '0 : ITEM_W'(r_back);
            r_out_count  <= COUNT_W'(r_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_front_item  = r_out_front;
    assign o_back_item   = r_out_back;
    assign o_entry_count = r_out_count;

    `OLU_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY), "count above capacity")
    `OLU_ASSERT(a_count_step, i_clk, i_rst_n, (r_count == $past(r_count)) || (r_count == $past(r_count) + CNT_W'(1)) || (r_count + CNT_W'(1) == $past(r_count)), "count moved by more than one")
    `OLU_ASSERT(a_shift_idx, i_clk, i_rst_n, (i_cmd.op == OP_SHIFT_STEP) |-> (idx_ext + CMP_W'(2) < cnt_ext), "shift read past the back entry")
endmodule

@@ sv/ordered_list_engine_unit.sv @@
// Top level of the ordered list engine: a bounded double-ended queue with delete by index.
// Depends on olq_pkg, olq_req_if, olq_rsp_if, olq_ctrl, olq_dp (with olq_ram).
//
//   channel  | dir | beat fields
//   ---------+-----+--------------------------------------------------
//   i_req    | in  | func[2:0], item[15:0], position[7:0]
//   o_rsp    | out | status[1:0], front_item[15:0], back_item[15:0],
//            |     | entry_count[8:0]
//
// One request is worked at a time. A push, a failed request or an unused code goes
// from accept through the execute state to the result state; a pop or a delete of the
// back entry that leaves entries behind adds a fetch state for the RAM read of the new
// end entry. A delete inside the list moves the later entries one slot forward through
// the single RAM port pair. Reset clears head, count and the handshake state; the entry
// RAM is not cleared. The result sits in an output register, so the next request beat is
// taken while a result beat is stalled; a later result waits until that register drains.
module ordered_list_engine_unit import olq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    olq_req_if.sink   i_req,
    olq_rsp_if.source o_rsp
);
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_req_ready;

    // Sequencer: accept, execute, optional fetch or shift, hand the result to the output
    olq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Ring storage, front/back cache and the result register
    olq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_func        (i_req.func),
        .i_item        (i_req.item),
        .i_pos         (i_req.position),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_front_item  (o_rsp.front_item),
        .o_back_item   (o_rsp.back_item),
        .o_entry_count (o_rsp.entry_count)
    );

    assign i_req.ready = w_req_ready;
endmodule
